// ----- hw/rtl/fbse_pkg.sv -----
`default_nettype none
package fbse_pkg;

    localparam logic [3:0] CMD_RAISE    = 4'd0;
    localparam logic [3:0] CMD_CLR_ONE  = 4'd1;
    localparam logic [3:0] CMD_CLR_CUR  = 4'd2;
    localparam logic [3:0] CMD_COUNT    = 4'd3;
    localparam logic [3:0] CMD_QUERY    = 4'd4;
    localparam logic [3:0] CMD_LIST_CUR = 4'd5;
    localparam logic [3:0] CMD_LIST_REG = 4'd6;
    localparam logic [3:0] CMD_CLR_REG  = 4'd7;
    localparam logic [3:0] CMD_TEST     = 4'd8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_COMPANY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_TABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_COUNT  = 2'd2;

    localparam logic [15:0] COMPANY_RESET = 16'h005d;
    localparam int RESULT_LIMIT = 64;

    typedef struct packed {
        logic accept;
        logic count_step;
        logic list_step;
    } t_ctl;

    typedef struct packed {
        logic scan;
        logic is_list;
        logic count_end;
        logic total_zero;
        logic list_end;
    } t_sts;

    typedef struct packed {
        logic [7:0]  fault_out;
        logic [8:0]  fault_total;
        logic        is_current;
        logic [7:0]  reported_test;
        logic [15:0] reported_company;
        logic        list_empty;
        logic        mismatch;
        logic        code_range_error;
        logic        last;
    } t_res;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fbse_ctrl.sv -----
`default_nettype none
module fbse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire fbse_pkg::t_sts i_sts,
    output fbse_pkg::t_ctl     o_ctl,
    output logic               busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_COUNT = 3'b010,
        S_LIST  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                o_ctl.accept = start;
                if (start && i_sts.scan) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                o_ctl.count_step = 1'b1;
                if (i_sts.count_end) begin
                    n_state = (!i_sts.is_list || i_sts.total_zero) ? S_IDLE : S_LIST;
                end
            end
            S_LIST: begin
                o_ctl.list_step = 1'b1;
                if (i_sts.list_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/fbse_dp.sv -----
`default_nettype none
module fbse_dp #(
    parameter int FAULT_CODES = 64,
    parameter int MAX_TESTS   = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire fbse_pkg::t_ctl                     i_ctl,
    output fbse_pkg::t_sts                          o_sts,
    input  wire logic                               i_cfg_we,
    input  wire logic [fbse_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [63:0]                        i_cfg_wdata,
    input  wire logic [3:0]                         i_cmd,
    input  wire logic [7:0]                         i_fault_code,
    input  wire logic [15:0]                        i_company,
    input  wire logic [7:0]                         i_test_number,
    output logic                                    o_valid,
    output fbse_pkg::t_res                          o_res
);

    localparam int IDXW   = $clog2(FAULT_CODES);
    localparam int CHUNKS = (FAULT_CODES + 7) / 8;
    localparam int CIW    = $clog2(CHUNKS);
    localparam int PADW   = CHUNKS * 8;
    localparam int NEW    = $clog2(fbse_pkg::RESULT_LIMIT + 1);

    logic [FAULT_CODES-1:0] r_reg_map;
    logic [FAULT_CODES-1:0] r_cur_map;
    logic [7:0]             r_recent_test;
    logic [15:0]            r_own_company;
    logic [63:0]            r_test_table;
    logic [3:0]             r_test_count;
    logic                   r_sel_reg;
    logic                   r_is_list;
    logic [IDXW-1:0]        r_scan;
    logic [8:0]             r_total;
    logic [NEW-1:0]         r_nemit;
    logic                   r_valid;
    fbse_pkg::t_res         r_res;

    fbse_pkg::t_res         n_res;
    logic                   n_emit;

    logic                   w_company_ok;
    logic                   w_scan;
    logic                   w_in_range;
    logic [IDXW-1:0]        w_idx;
    logic [3:0]             w_tcnt;
    logic                   w_found;
    logic [FAULT_CODES-1:0] w_map;
    logic [PADW-1:0]        w_pad;
    logic [7:0]             w_chunk [CHUNKS];
    logic [8:0]             w_total;
    logic                   w_count_end;
    logic                   w_bit;
    logic                   w_last;
    logic                   w_list_end;

    assign w_company_ok = (i_company == r_own_company);
    assign w_scan = (i_cmd == fbse_pkg::CMD_COUNT) || (i_cmd == fbse_pkg::CMD_LIST_CUR)
                 || ((i_cmd == fbse_pkg::CMD_LIST_REG) && w_company_ok);
    assign w_in_range = ({1'b0, i_fault_code} < 9'(FAULT_CODES));
    assign w_idx = i_fault_code[IDXW-1:0];

    always_comb begin
        w_tcnt  = (r_test_count > 4'(MAX_TESTS)) ? 4'(MAX_TESTS) : r_test_count;
        w_found = 1'b0;
        for (int i = 0; i < MAX_TESTS; i++) begin
            if ((4'(i) < w_tcnt) && (r_test_table[i*8 +: 8] == i_test_number)) begin
                w_found = 1'b1;
            end
        end
        w_found = w_found && w_company_ok;
    end

    assign w_map = r_sel_reg ? r_reg_map : r_cur_map;
    assign w_pad = PADW'(w_map);

    for (genvar g = 0; g < CHUNKS; g++) begin : g_chunk
        assign w_chunk[g] = w_pad[g*8 +: 8];
    end

    assign w_total     = r_total + 9'(fbse_pkg::popcount8(w_chunk[r_scan[CIW-1:0]]));
    assign w_count_end = (r_scan[CIW-1:0] == CIW'(CHUNKS - 1));
    assign w_bit       = w_map[r_scan];
    assign w_last      = ((9'(r_nemit) + 9'd1) == r_total)
                      || (r_nemit == NEW'(fbse_pkg::RESULT_LIMIT - 1));
    assign w_list_end  = (w_bit && w_last) || (r_scan == IDXW'(FAULT_CODES - 1));

    assign o_sts.scan       = w_scan;
    assign o_sts.is_list    = r_is_list;
    assign o_sts.count_end  = w_count_end;
    assign o_sts.total_zero = (w_total == 9'd0);
    assign o_sts.list_end   = w_list_end;

    always_comb begin
        n_res  = '0;
        n_emit = 1'b0;
        if (i_ctl.accept && !w_scan) begin
            n_emit     = 1'b1;
            n_res.last = 1'b1;
            case (i_cmd)
                fbse_pkg::CMD_RAISE, fbse_pkg::CMD_CLR_ONE: begin
                    n_res.code_range_error = !w_in_range;
                end
                fbse_pkg::CMD_QUERY: begin
                    n_res.code_range_error = !w_in_range;
                    n_res.is_current       = w_in_range && r_cur_map[w_idx];
                end
                fbse_pkg::CMD_LIST_REG: begin
                    n_res.mismatch = 1'b1;
                end
                fbse_pkg::CMD_TEST: begin
                    n_res.mismatch = !w_found;
                end
                default: begin
                end
            endcase
        end else if (i_ctl.count_step && w_count_end) begin
            n_emit     = !r_is_list || (w_total == 9'd0);
            n_res.last = 1'b1;
            if (r_is_list) begin
                n_res.reported_test    = r_recent_test;
                n_res.reported_company = r_own_company;
                n_res.list_empty       = 1'b1;
            end else begin
                n_res.fault_total = w_total;
            end
        end else if (i_ctl.list_step && w_bit) begin
            n_emit                 = 1'b1;
            n_res.fault_out        = 8'(r_scan);
            n_res.fault_total      = r_total;
            n_res.reported_test    = r_recent_test;
            n_res.reported_company = r_own_company;
            n_res.last             = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_map     <= '0;
            r_cur_map     <= '0;
            r_recent_test <= 8'd0;
            r_own_company <= fbse_pkg::COMPANY_RESET;
            r_test_table  <= 64'd0;
            r_test_count  <= 4'd0;
            r_sel_reg     <= 1'b0;
            r_is_list     <= 1'b0;
            r_scan        <= '0;
            r_total       <= 9'd0;
            r_nemit       <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= n_emit;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fbse_pkg::CFG_OWN_COMPANY: r_own_company <= i_cfg_wdata[15:0];
                    fbse_pkg::CFG_TEST_TABLE:  r_test_table  <= i_cfg_wdata;
                    fbse_pkg::CFG_TEST_COUNT:  r_test_count  <= i_cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
            if (i_ctl.accept) begin
                r_scan    <= '0;
                r_total   <= 9'd0;
                r_nemit   <= '0;
                r_is_list <= (i_cmd != fbse_pkg::CMD_COUNT);
                r_sel_reg <= (i_cmd == fbse_pkg::CMD_LIST_REG);
                if (!w_scan) begin
                    case (i_cmd)
                        fbse_pkg::CMD_RAISE: begin
                            if (w_in_range) begin
                                r_reg_map[w_idx] <= 1'b1;
                                r_cur_map[w_idx] <= 1'b1;
                            end
                        end
                        fbse_pkg::CMD_CLR_ONE: begin
                            if (w_in_range) begin
                                r_cur_map[w_idx] <= 1'b0;
                            end
                        end
                        fbse_pkg::CMD_CLR_CUR: r_cur_map <= '0;
                        fbse_pkg::CMD_CLR_REG: r_reg_map <= '0;
                        fbse_pkg::CMD_TEST: begin
                            if (w_found) begin
                                r_recent_test <= i_test_number;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (i_ctl.count_step) begin
                r_total <= w_total;
                r_scan  <= w_count_end ? '0 : r_scan + 1'b1;
            end
            if (i_ctl.list_step) begin
                r_scan <= r_scan + 1'b1;
                if (w_bit) begin
                    r_nemit <= r_nemit + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ----- hw/rtl/fault_bitmap_status_engine_top.sv -----
`default_nettype none
// Fault status engine: keeps a registered and a current fault bitmap of
// FAULT_CODES bits and answers one command per request taken on start while
// busy is low. Raise, clear, query, clear-all, self-test and unknown commands,
// and a registered list refused for a wrong company, give their single result
// on o_valid in the cycle after the request and leave busy low, so a new
// request may follow at once. Count and accepted list commands first sweep
// the selected bitmap eight codes a cycle to get the fault total; a count
// result then follows, a list with a zero total gives one list-empty
// result, and any other list walks the codes one per cycle and strobes each
// set code in ascending order, ending at the last set code (or after 64
// results). busy stays high for that whole walk. Results are strobed for a
// single cycle and cannot be held off, so the receiver must take every
// o_valid cycle. The user must write configuration through i_cfg_we only
// while no command is in progress; the block does not enforce this.
module fault_bitmap_status_engine_top #(
    parameter int FAULT_CODES = 64,
    parameter int MAX_TESTS   = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_cfg_we,
    input  wire logic [fbse_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]                    i_cfg_wdata,
    input  wire logic [3:0]                     i_cmd,
    input  wire logic [7:0]                     i_fault_code,
    input  wire logic [15:0]                    i_company,
    input  wire logic [7:0]                     i_test_number,
    output logic                                o_valid,
    output logic [7:0]                          o_fault_out,
    output logic [8:0]                          o_fault_total,
    output logic                                o_is_current,
    output logic [7:0]                          o_reported_test,
    output logic [15:0]                         o_reported_company,
    output logic                                o_list_empty,
    output logic                                o_mismatch,
    output logic                                o_code_range_error,
    output logic                                o_last
);

    fbse_pkg::t_ctl w_ctl;
    fbse_pkg::t_sts w_sts;
    fbse_pkg::t_res w_res;

    fbse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .busy    (busy)
    );

    fbse_dp #(
        .FAULT_CODES (FAULT_CODES),
        .MAX_TESTS   (MAX_TESTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_fault_code  (i_fault_code),
        .i_company     (i_company),
        .i_test_number (i_test_number),
        .o_valid       (o_valid),
        .o_res         (w_res)
    );

    assign o_fault_out        = w_res.fault_out;
    assign o_fault_total      = w_res.fault_total;
    assign o_is_current       = w_res.is_current;
    assign o_reported_test    = w_res.reported_test;
    assign o_reported_company = w_res.reported_company;
    assign o_list_empty       = w_res.list_empty;
    assign o_mismatch         = w_res.mismatch;
    assign o_code_range_error = w_res.code_range_error;
    assign o_last             = w_res.last;

endmodule
`default_nettype wire
